FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the polygon intersection block.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst, ante, cons)
`define ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/cpit_pkg.sv
// Package for the convex polygon intersection test: sizes, codes, point type.
// No dependencies.
`timescale 1ns / 1ps
package cpit_pkg;
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 31;
  localparam int PW           = COORD_BITS + 1;          // stored point coordinate
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int PROD_W       = 2 * PW;

  localparam logic OP_A = 1'b0;
  localparam logic OP_B = 1'b1;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_EMPTY    = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_FETCH, S_EDGE, S_EMUL, S_DECIDE,
    S_SMUL, S_CHECK, S_FMUL, S_FCHK, S_DONE
  } state_t;

  typedef struct packed {
    logic signed [PW-1:0] y;
    logic signed [PW-1:0] x;
  } pt_t;

  function automatic pt_t pt_add(pt_t p, pt_t q);
    pt_t r;
    r.x = p.x + q.x;
    r.y = p.y + q.y;
    return r;
  endfunction

  function automatic pt_t pt_sub(pt_t p, pt_t q);
    pt_t r;
    r.x = p.x - q.x;
    r.y = p.y - q.y;
    return r;
  endfunction

  function automatic logic lex_less(pt_t p, pt_t q);
    return (p.x == q.x) ? (p.y < q.y) : (p.x < q.x);
  endfunction

  // circular successor of an index within a polygon of cnt vertices
  function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] idx,
                                                logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    return (inc == cnt) ? '0 : inc[IDX_W-1:0];
  endfunction
endpackage

FILE: sv/convex_polygon_intersection_test_core.sv
// Convex polygon intersection test by Minkowski difference walk.
// Depends on cpit_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
//
// Channel | Beat                            | Handshake
// vertex  | op, vx, vy, last_vertex          | vtx_valid / vtx_stall
// result  | intersects, status               | res_valid / res_stall
//
// A vertex beat that does not close the pair leaves the block in S_IDLE, ready for the next beat.
// A closing beat runs the merge walk: INIT, then FETCH, EDGE, EMUL, DECIDE, SMUL and CHECK
// for each of the n+m-1 sum edges, then FMUL, FCHK and DONE; the single vertex memory read
// port per polygon and the shared 32x32 multiplier pair set this order of steps.
// Capacity or empty errors skip the walk and go straight to S_DONE.
// rst is synchronous; vtx_stall is high whenever the walk is in progress,
// and a finished result waits in the output register while loads go on.
module convex_polygon_intersection_test_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  vtx_valid,
  output logic                                  vtx_stall,
  input  logic                                  op,
  input  logic signed [cpit_pkg::COORD_BITS-1:0] vx,
  input  logic signed [cpit_pkg::COORD_BITS-1:0] vy,
  input  logic                                  last_vertex,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic                                  intersects,
  output logic [1:0]                            status
);
  import cpit_pkg::*;

  state_t state, state_next;

  // vertex stores; B is kept negated
  pt_t a_mem [MAX_VERTICES];
  pt_t b_mem [MAX_VERTICES];
  pt_t a_rd, b_rd;
  logic rd_en;

  logic [CNT_W-1:0] a_count, b_count;
  logic [IDX_W-1:0] a_min_idx, b_min_idx;
  pt_t              a_min_pt, b_min_pt;
  logic             overflow_seen;

  // walk registers
  pt_t              acur, bcur, first, prev, cur, ea, eb;
  logic [IDX_W-1:0] pa, pb;
  logic [CNT_W-1:0] i, j;
  logic [CNT_W:0]   rem;
  logic             in_hull;
  logic signed [PROD_W-1:0] prod1, prod2;
  logic signed [PW-1:0]     m1a, m1b, m2a, m2b;
  logic signed [PROD_W:0]   diff;
  logic             diff_neg, diff_pos;

  status_t res_st;
  logic    res_hit;

  // load path
  logic             accept, is_b, room, new_min, ovf_after, done_take;
  pt_t              pin, sel_min;
  logic [CNT_W-1:0] sel_count, a_after, b_after;
  status_t          load_st;

  assign accept = vtx_valid && !vtx_stall;
  assign is_b   = (op == OP_B);

  always_comb begin
    pin.x = PW'(vx);
    pin.y = PW'(vy);
    if (is_b) begin
      pin.x = -pin.x;
      pin.y = -pin.y;
    end
    sel_count = is_b ? b_count : a_count;
    sel_min   = is_b ? b_min_pt : a_min_pt;
    room      = sel_count < CNT_W'(MAX_VERTICES);
    new_min   = (sel_count == '0) || lex_less(pin, sel_min);
    ovf_after = overflow_seen || !room;
    a_after   = a_count + CNT_W'(!is_b && room);
    b_after   = b_count + CNT_W'(is_b && room);
    if (ovf_after) begin
      load_st = ST_OVERFLOW;
    end else if (a_after == '0 || b_after == '0) begin
      load_st = ST_EMPTY;
    end else begin
      load_st = ST_OK;
    end
  end

  // sign of the cross product held in the product registers
  assign diff     = {prod1[PROD_W-1], prod1} - {prod2[PROD_W-1], prod2};
  assign diff_neg = diff[PROD_W];
  assign diff_pos = !diff[PROD_W] && (diff != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && last_vertex) begin
          state_next = (load_st == ST_OK) ? S_INIT : S_DONE;
        end
      end
      S_INIT: begin
        state_next = ((CNT_W+1)'(a_count) + (CNT_W+1)'(b_count) > (CNT_W+1)'(1)) ?
                     S_FETCH : S_FMUL;
      end
      S_FETCH:  state_next = S_EDGE;
      S_EDGE:   state_next = S_EMUL;
      S_EMUL:   state_next = S_DECIDE;
      S_DECIDE: state_next = S_SMUL;
      S_SMUL:   state_next = S_CHECK;
      S_CHECK:  state_next = (rem > (CNT_W+1)'(1)) ? S_FETCH : S_FMUL;
      S_FMUL:   state_next = S_FCHK;
      S_FCHK:   state_next = S_DONE;
      S_DONE: begin
        if (done_take) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // control outputs and multiplier operand select
  always_comb begin
    vtx_stall = (state != S_IDLE);
    rd_en     = (state == S_FETCH);
    done_take = (state == S_DONE) && (!res_valid || !res_stall);
    m1a = ea.x;
    m1b = eb.y;
    m2a = ea.y;
    m2b = eb.x;
    case (state)
      S_SMUL: begin
        m1a = prev.x;
        m1b = cur.y;
        m2a = prev.y;
        m2b = cur.x;
      end
      S_FMUL: begin
        m1a = prev.x;
        m1b = first.y;
        m2a = prev.y;
        m2b = first.x;
      end
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && room) begin
      if (is_b) begin
        b_mem[b_count[IDX_W-1:0]] <= pin;
      end else begin
        a_mem[a_count[IDX_W-1:0]] <= pin;
      end
    end
    if (rd_en) begin
      a_rd <= a_mem[next_idx(pa, a_count)];
      b_rd <= b_mem[next_idx(pb, b_count)];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      a_count       <= '0;
      b_count       <= '0;
      a_min_idx     <= '0;
      b_min_idx     <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (!room) begin
          overflow_seen <= 1'b1;
        end else if (is_b) begin
          b_count <= b_count + CNT_W'(1);
          if (new_min) b_min_idx <= b_count[IDX_W-1:0];
        end else begin
          a_count <= a_count + CNT_W'(1);
          if (new_min) a_min_idx <= a_count[IDX_W-1:0];
        end
      end
      if (done_take) begin
        a_count       <= '0;
        b_count       <= '0;
        a_min_idx     <= '0;
        b_min_idx     <= '0;
        overflow_seen <= 1'b0;
        res_valid     <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod1 <= m1a * m1b;
    prod2 <= m2a * m2b;
    if (accept && room && new_min) begin
      if (is_b) b_min_pt <= pin;
      else      a_min_pt <= pin;
    end
    if (state == S_IDLE && accept && last_vertex) begin
      res_st  <= load_st;
      res_hit <= 1'b0;
    end
    if (done_take) begin
      intersects <= res_hit;
      status     <= res_st;
    end
    case (state)
      S_INIT: begin
        acur    <= a_min_pt;
        bcur    <= b_min_pt;
        pa      <= a_min_idx;
        pb      <= b_min_idx;
        i       <= '0;
        j       <= '0;
        rem     <= (CNT_W+1)'(a_count) + (CNT_W+1)'(b_count);
        first   <= pt_add(a_min_pt, b_min_pt);
        prev    <= pt_add(a_min_pt, b_min_pt);
        in_hull <= 1'b1;
      end
      S_EDGE: begin
        ea <= pt_sub(a_rd, acur);
        eb <= pt_sub(b_rd, bcur);
      end
      S_DECIDE: begin
        rem <= rem - (CNT_W+1)'(1);
        // advance along A when its edge turns first, or B is used up
        if ((i != a_count && diff_neg) || j == b_count) begin
          i    <= i + CNT_W'(1);
          acur <= a_rd;
          pa   <= next_idx(pa, a_count);
          cur  <= pt_add(a_rd, bcur);
        end else begin
          j    <= j + CNT_W'(1);
          bcur <= b_rd;
          pb   <= next_idx(pb, b_count);
          cur  <= pt_add(acur, b_rd);
        end
      end
      S_CHECK: begin
        if (diff_pos) in_hull <= 1'b0;
        prev <= cur;
      end
      S_FCHK: begin
        res_hit <= in_hull && !diff_pos;
      end
      default: ;
    endcase
  end

  `ASSERT_IMP(a_accept_idle, clk, rst, accept, state == S_IDLE)
  `ASSERT_IMP(a_walk_nonempty, clk, rst, state == S_FETCH, a_count != '0 && b_count != '0)
  `ASSERT_IMP(a_walk_bounds, clk, rst, state == S_DECIDE, i <= a_count && j <= b_count)
  `ASSERT_NXT(a_done_loads, clk, rst, done_take, res_valid && state == S_IDLE)

endmodule

FILE: dv/tb_convex_polygon_intersection_test_core.sv
// Self-checking bench for convex_polygon_intersection_test_core: directed pairs, then random ones.
// Depends on cpit_pkg and the core RTL; holds its own predictor of the Minkowski walk.
`timescale 1ns / 1ps
module tb_convex_polygon_intersection_test_core;
  import cpit_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic [0:0] op;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic last;
  } beat_t;

  typedef struct {
    logic hit;
    status_t st;
  } verdict_t;

  // One row of the directed table. chk = 1 means exp_* was typed in by hand.
  typedef struct {
    logic [0:0] op;
    int vx;
    int vy;
    logic last;
    logic chk;
    logic exp_hit;
    status_t exp_st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vtx_valid = 1'b0;
  logic vtx_stall;
  logic op = OP_A;
  logic signed [CW-1:0] vx = '0;
  logic signed [CW-1:0] vy = '0;
  logic last_vertex = 1'b0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic intersects;
  logic [1:0] status;

  convex_polygon_intersection_test_core dut (
    .clk(clk), .rst(rst),
    .vtx_valid(vtx_valid), .vtx_stall(vtx_stall),
    .op(op), .vx(vx), .vy(vy), .last_vertex(last_vertex),
    .res_valid(res_valid), .res_stall(res_stall),
    .intersects(intersects), .status(status)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  // Mirror of the block's pair state. B is stored negated.
  longint pa_x[MAX_VERTICES], pa_y[MAX_VERTICES];
  longint pb_x[MAX_VERTICES], pb_y[MAX_VERTICES];
  int na, nb, mina, minb;
  bit spill;

  verdict_t pending_verdicts[$];
  beat_t vertex_stream[$];
  int n_fail = 0, n_beats = 0, n_verdicts = 0, n_hits = 0, n_errs = 0;
  int idle_cycles = 0;

  // Coordinates are at most 33 bits here, so products fit in 66 bits; 128 is plenty.
  function automatic int cross_sgn(longint px, longint py, longint qx, longint qy);
    logic signed [127:0] d;
    d = 128'(px) * 128'(qy) - 128'(py) * 128'(qx);
    return (d < 0) ? -1 : (d == 0) ? 0 : 1;
  endfunction

  function automatic bit pt_lt(longint ax, longint ay, longint bx, longint by);
    return (ax == bx) ? (ay < by) : (ax < bx);
  endfunction

  function automatic void sum_pt(int i, int j, output longint sx, output longint sy);
    int ia, ib;
    ia = (mina + i) % na;
    ib = (minb + j) % nb;
    sx = pa_x[ia] + pb_x[ib];
    sy = pa_y[ia] + pb_y[ib];
  endfunction

  // Origin-in-Minkowski-difference walk: merge edges by cross order,
  // any sum edge that leaves the origin strictly on its left means no overlap.
  function automatic bit origin_in_sum();
    int i, j;
    bit in_hull;
    longint fx, fy, px, py, cx, cy, eax, eay, ebx, eby;
    i = 0; j = 0; in_hull = 1;
    sum_pt(0, 0, fx, fy);
    px = fx; py = fy;
    while (na - i + nb - j > 1) begin
      eax = pa_x[(mina + i + 1) % na] - pa_x[(mina + i) % na];
      eay = pa_y[(mina + i + 1) % na] - pa_y[(mina + i) % na];
      ebx = pb_x[(minb + j + 1) % nb] - pb_x[(minb + j) % nb];
      eby = pb_y[(minb + j + 1) % nb] - pb_y[(minb + j) % nb];
      if ((i != na && cross_sgn(eax, eay, ebx, eby) < 0) || j == nb) i++;
      else j++;
      sum_pt(i, j, cx, cy);
      if (cross_sgn(px, py, cx, cy) > 0) in_hull = 0;
      px = cx; py = cy;
    end
    if (cross_sgn(px, py, fx, fy) > 0) in_hull = 0;
    return in_hull;
  endfunction

  function automatic void pair_clear();
    na = 0; nb = 0; mina = 0; minb = 0; spill = 0;
  endfunction

  // Absorb one accepted vertex beat; queue a verdict when it closes the pair.
  function automatic void absorb_vertex(beat_t b);
    longint x, y;
    verdict_t v;
    x = longint'(b.vx);
    y = longint'(b.vy);
    if (b.op == OP_A) begin
      if (na < MAX_VERTICES) begin
        pa_x[na] = x; pa_y[na] = y;
        if (na == 0 || pt_lt(x, y, pa_x[mina], pa_y[mina])) mina = na;
        na++;
      end else spill = 1;
    end else begin
      x = -x; y = -y;
      if (nb < MAX_VERTICES) begin
        pb_x[nb] = x; pb_y[nb] = y;
        if (nb == 0 || pt_lt(x, y, pb_x[minb], pb_y[minb])) minb = nb;
        nb++;
      end else spill = 1;
    end
    if (!b.last) return;
    v.hit = 0;
    if (spill) v.st = ST_OVERFLOW;
    else if (na == 0 || nb == 0) v.st = ST_EMPTY;
    else begin
      v.st = ST_OK;
      v.hit = origin_in_sum();
    end
    pending_verdicts.push_back(v);
    pair_clear();
  endfunction

  // ---------------------------------------------------------------- stimulus
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));

  // Directed rows: hand-typed verdicts only for error codes and obvious geometry.
  row_t directed_rows[] = '{
    // empty pair: a lone closing B vertex, then a lone closing A vertex
    '{OP_B, 0, 0, 1'b1, 1'b1, 1'b0, ST_EMPTY},
    '{OP_A, 5, 5, 1'b1, 1'b1, 1'b0, ST_EMPTY},
    // single point vs same point: touching
    '{OP_A, 7, -3, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, 7, -3, 1'b1, 1'b1, 1'b1, ST_OK},
    // extreme corners, closing on an A vertex
    '{OP_A, CMIN, CMIN, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_A, CMIN, CMAX, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_A, CMAX, CMAX, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, CMAX, CMIN, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, CMIN, CMIN, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_A, CMAX, CMIN, 1'b1, 1'b0, 1'b0, ST_OK},
    // far apart single points: degenerate sum, only the side test applies
    '{OP_A, CMAX, CMAX, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, CMIN, CMIN, 1'b1, 1'b0, 1'b0, ST_OK},
    // collinear segments, overlapping: degenerate sum
    '{OP_A, 0, 0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_A, 10, 0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, 5, 0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, 20, 0, 1'b1, 1'b0, 1'b0, ST_OK},
    // triangles sharing only an edge (boundary contact)
    '{OP_A, 0, 0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_A, 0, 10, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_A, 10, 0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, 0, 10, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, 10, 10, 1'b0, 1'b0, 1'b0, ST_OK},
    '{OP_B, 10, 0, 1'b1, 1'b0, 1'b0, ST_OK}
  };

  function automatic beat_t mk_beat(logic [0:0] o, longint x, longint y, logic l);
    beat_t b;
    b.op = o; b.vx = CW'(x); b.vy = CW'(y); b.last = l;
    return b;
  endfunction

  function automatic int rnd_coord(int span);
    int r;
    case ($urandom_range(0, 9))
      0: r = CMAX;
      1: r = CMIN;
      2: r = int'($urandom()) >>> 1;
      default: r = int'($urandom_range(0, 2 * span)) - span;
    endcase
    return r;
  endfunction

  // Convex polygon in clockwise order: points on a circle-ish set of angles.
  task automatic push_convex(logic [0:0] o, int n, logic close_last);
    int cx, cy, rad, k, a;
    real ang;
    cx = $urandom_range(0, 400) - 200;
    cy = $urandom_range(0, 400) - 200;
    rad = $urandom_range(1, 150);
    if ($urandom_range(0, 15) == 0) rad = 1 << 28;
    a = $urandom_range(0, 359);
    for (k = 0; k < n; k++) begin
      ang = -2.0 * 3.14159265 * (real'(k) / real'(n)) + real'(a) / 57.3;
      vertex_stream.push_back(mk_beat(o, cx + $rtoi(rad * $cos(ang)),
                                      cy + $rtoi(rad * $sin(ang)),
                                      close_last && k == n - 1));
    end
  endtask

  task automatic build_random();
    int pairs, k, na_r, nb_r, sel;
    for (pairs = 0; vertex_stream.size() < 1800; pairs++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) begin
        // overflow: more than capacity A vertices
        for (k = 0; k < MAX_VERTICES + $urandom_range(1, 3); k++)
          vertex_stream.push_back(mk_beat(OP_A, rnd_coord(1000), rnd_coord(1000), 1'b0));
        vertex_stream.push_back(mk_beat(OP_B, 0, 0, 1'b1));
      end else if (sel == 1) begin
        // raw noise: random fields, random length
        for (k = 0; k < $urandom_range(1, 6); k++)
          vertex_stream.push_back(mk_beat(1'($urandom_range(0, 1)), rnd_coord(1 << 20),
                                          rnd_coord(1 << 20), 1'b0));
        vertex_stream.push_back(mk_beat(1'($urandom_range(0, 1)), rnd_coord(50),
                                        rnd_coord(50), 1'b1));
      end else begin
        na_r = ($urandom_range(0, 9) == 0) ? MAX_VERTICES : $urandom_range(1, 8);
        nb_r = ($urandom_range(0, 9) == 0) ? MAX_VERTICES : $urandom_range(1, 8);
        push_convex(OP_A, na_r, 1'b0);
        push_convex(OP_B, nb_r, 1'b1);
      end
    end
  endtask

  // ---------------------------------------------------------------- driver
  // Bursts of random length with random gaps; valid ignores stall.
  task automatic drive_stream();
    int burst, gap;
    beat_t b;
    while (vertex_stream.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && vertex_stream.size() > 0) begin
        b = vertex_stream[0];
        vtx_valid <= 1'b1;
        op <= b.op; vx <= b.vx; vy <= b.vy; last_vertex <= b.last;
        @(posedge clk);
        while (vtx_stall) @(posedge clk);
        void'(vertex_stream.pop_front());
        absorb_vertex(b);
        n_beats++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        vtx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    vtx_valid <= 1'b0;
  endtask

  // Expected verdicts from the closing directed rows, flagged where typed by hand, checked against the predictor.
  verdict_t typed_verdicts[$];
  bit typed_flags[$];

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && res_valid && !res_stall) begin
      n_verdicts++;
      if (intersects) n_hits++;
      if (status != ST_OK) n_errs++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict intersects=%0b status=%0d",
                 $time, intersects, status);
        n_fail++;
      end else begin
        e = pending_verdicts.pop_front();
        if (typed_flags.size() > 0) begin
          // hand-typed value must agree with what the predictor queued
          if (typed_flags.pop_front() && (typed_verdicts[0].hit != e.hit ||
                                          typed_verdicts[0].st != e.st)) begin
            $display("%0t: typed row disagrees: typed %0b/%0d predicted %0b/%0d", $time,
                     typed_verdicts[0].hit, typed_verdicts[0].st, e.hit, e.st);
            n_fail++;
          end
          void'(typed_verdicts.pop_front());
        end
        if (intersects !== e.hit) begin
          $display("%0t: intersects expected %0b actual %0b", $time, e.hit, intersects);
          n_fail++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          n_fail++;
        end
      end
    end
  end

  // Receiver stall pattern plus one long hold-off while the sender keeps going.
  bit hold_off = 0;
  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else if (hold_off) res_stall <= 1'b1;
    else if (n_beats < 300) res_stall <= 1'b0;
    else res_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    wait (n_beats >= 600);
    @(posedge clk);
    hold_off = 1;
    repeat (3000) @(posedge clk);
    hold_off = 0;
  end

  // Watchdog: cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (vtx_valid && !vtx_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    verdict_t tv;
    pair_clear();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed table
    foreach (directed_rows[k]) begin
      vertex_stream.push_back(mk_beat(directed_rows[k].op, directed_rows[k].vx,
                                      directed_rows[k].vy, directed_rows[k].last));
      if (directed_rows[k].last) begin
        tv.hit = directed_rows[k].exp_hit;
        tv.st = directed_rows[k].exp_st;
        typed_verdicts.push_back(tv);
        typed_flags.push_back(directed_rows[k].chk);
      end
    end
    build_random();
    drive_stream();
    wait (pending_verdicts.size() == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d vertex beats, %0d verdicts (%0d overlapping, %0d error codes).",
             n_beats, n_verdicts, n_hits, n_errs);
    if (n_fail == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
